FILE: hw/rtl/lslf_pkg.sv
package lslf_pkg;

    localparam int MAX_POINTS   = 4096;
    localparam int CORDIC_STEPS = 16;

    localparam int CNT_W  = 13;
    localparam int IN_W   = 16;
    localparam int SQ1_W  = 32;
    localparam int SUM_W  = 28;
    localparam int SQ_W   = 44;
    localparam int HALF_W = 22;
    localparam int OPND_W = 29;
    localparam int PROD_W = 58;
    localparam int ACC_W  = 60;
    localparam int ANG_W  = 34;
    localparam int STEP_W = 5;
    localparam int DIV_W  = 30;
    localparam int FRAC_BITS = 30;
    localparam int Q14_W  = 16;
    localparam int LC_W   = 17;

    localparam logic signed [ANG_W-1:0] ROT_START = 34'sd652032874;

    typedef enum logic [1:0] {
        FS_OK       = 2'd0,
        FS_UNDEF    = 2'd1,
        FS_OVERFLOW = 2'd2
    } fit_status_t;

    typedef enum logic [3:0] {
        OP_N_UV_LO = 4'd0,
        OP_N_UV_HI = 4'd1,
        OP_SU_SV   = 4'd2,
        OP_N_UU_LO = 4'd3,
        OP_N_UU_HI = 4'd4,
        OP_N_VV_LO = 4'd5,
        OP_N_VV_HI = 4'd6,
        OP_SU_SU   = 4'd7,
        OP_SV_SV   = 4'd8,
        OP_SU_LA   = 4'd9,
        OP_SV_LB   = 4'd10
    } mop_t;

    typedef struct packed {
        logic               in_ready;
        logic               mul;
        logic               acc;
        mop_t               op;
        logic               check;
        logic               norm;
        logic               vec;
        logic               rot_init;
        logic               rot;
        logic               fin;
        logic               div_init;
        logic               div;
        logic               load;
        logic [STEP_W-1:0]  step;
    } lslf_cmd_t;

    typedef struct packed {
        logic overflowed;
        logic ab_zero;
        logic norm_ok;
        logic out_free;
    } lslf_stat_t;

    function automatic logic [ANG_W-1:0] atan_step(input logic [STEP_W-1:0] i);
        logic [ANG_W-1:0] r;
        r = '0;
        if (i <= STEP_W'(FRAC_BITS))
        begin
            r = ANG_W'(1) << (STEP_W'(FRAC_BITS) - i);
        end
        unique case (i)
            5'd0:  r = ANG_W'(843314857);
            5'd1:  r = ANG_W'(497837829);
            5'd2:  r = ANG_W'(263043837);
            5'd3:  r = ANG_W'(133525159);
            5'd4:  r = ANG_W'(67021687);
            5'd5:  r = ANG_W'(33543516);
            5'd6:  r = ANG_W'(16775851);
            5'd7:  r = ANG_W'(8388437);
            5'd8:  r = ANG_W'(4194283);
            5'd9:  r = ANG_W'(2097149);
            5'd10: r = ANG_W'(1048576);
            default: ;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/lslf_if.sv
interface lslf_pt_if;
    import lslf_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [IN_W-1:0]  point_u;
    logic signed [IN_W-1:0]  point_v;
    logic                    is_last;
    modport source (output valid, output point_u, output point_v, output is_last,
                    input ready);
    modport sink (input valid, input point_u, input point_v, input is_last,
                  output ready);
endinterface

interface lslf_line_if;
    import lslf_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [Q14_W-1:0] line_a;
    logic signed [Q14_W-1:0] line_b;
    logic signed [LC_W-1:0]  line_c;
    logic [1:0]              fit_status;
    modport source (output valid, output line_a, output line_b, output line_c,
                    output fit_status, input ready);
    modport sink (input valid, input line_a, input line_b, input line_c,
                  input fit_status, output ready);
endinterface

FILE: hw/rtl/lslf_ctrl.sv
module lslf_ctrl
    import lslf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_last,
    input  lslf_stat_t stat,
    output lslf_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_ACCUM, S_DRAIN, S_MUL, S_ACC, S_CHECK, S_NORM, S_VEC, S_ROT_INIT,
        S_ROT, S_FIN, S_DIV_INIT, S_DIV, S_LOAD
    } state_t;

    state_t             state_reg, state_next;
    mop_t               op_reg, op_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_ACCUM:
            begin
                if (in_valid && in_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_MUL;
                op_next    = OP_N_UV_LO;
            end
            S_MUL:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (op_reg == OP_SV_SV)
                begin
                    state_next = S_CHECK;
                end
                else if (op_reg == OP_SV_LB)
                begin
                    state_next = S_DIV_INIT;
                end
                else
                begin
                    op_next    = mop_t'(op_reg + 4'd1);
                    state_next = S_MUL;
                end
            end
            S_CHECK:
            begin
                state_next = (stat.overflowed || stat.ab_zero) ? S_LOAD : S_NORM;
            end
            S_NORM:
            begin
                if (stat.norm_ok)
                begin
                    state_next = S_VEC;
                    step_next  = '0;
                end
            end
            S_VEC:
            begin
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    state_next = S_ROT_INIT;
                end
                step_next = step_reg + STEP_W'(1);
            end
            S_ROT_INIT:
            begin
                state_next = S_ROT;
                step_next  = '0;
            end
            S_ROT:
            begin
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    state_next = S_FIN;
                end
                step_next = step_reg + STEP_W'(1);
            end
            S_FIN:
            begin
                state_next = S_MUL;
                op_next    = OP_SU_LA;
            end
            S_DIV_INIT:
            begin
                state_next = S_DIV;
                step_next  = '0;
            end
            S_DIV:
            begin
                if (step_reg == STEP_W'(DIV_W - 1))
                begin
                    state_next = S_LOAD;
                end
                step_next = step_reg + STEP_W'(1);
            end
            S_LOAD:
            begin
                if (stat.out_free)
                begin
                    state_next = S_ACCUM;
                end
            end
            default: state_next = S_ACCUM;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACCUM;
            op_reg    <= OP_N_UV_LO;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        cmd          = '0;
        cmd.op       = op_reg;
        cmd.step     = step_reg;
        cmd.in_ready = (state_reg == S_ACCUM);
        cmd.mul      = (state_reg == S_MUL);
        cmd.acc      = (state_reg == S_ACC);
        cmd.check    = (state_reg == S_CHECK);
        cmd.norm     = (state_reg == S_NORM);
        cmd.vec      = (state_reg == S_VEC);
        cmd.rot_init = (state_reg == S_ROT_INIT);
        cmd.rot      = (state_reg == S_ROT);
        cmd.fin      = (state_reg == S_FIN);
        cmd.div_init = (state_reg == S_DIV_INIT);
        cmd.div      = (state_reg == S_DIV);
        cmd.load     = (state_reg == S_LOAD);
    end

endmodule

FILE: hw/rtl/lslf_dp.sv
module lslf_dp
    import lslf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  lslf_cmd_t                cmd,
    output lslf_stat_t               stat,
    input  logic                     in_fire,
    input  logic signed [IN_W-1:0]   in_u,
    input  logic signed [IN_W-1:0]   in_v,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic signed [Q14_W-1:0]  out_a,
    output logic signed [Q14_W-1:0]  out_b,
    output logic signed [LC_W-1:0]   out_c,
    output logic [1:0]               out_status
);

    typedef enum logic [1:0] {DST_A, DST_B, DST_N} dst_t;

    function automatic logic signed [Q14_W-1:0] to_q14(input logic signed [ANG_W-1:0] v);
        logic signed [ANG_W:0] t;
        logic signed [ANG_W:0] r;
        t = (ANG_W+1)'(v) + (ANG_W+1)'(32768);
        r = t >>> 16;
        if (r > (ANG_W+1)'(16384))
        begin
            r = (ANG_W+1)'(16384);
        end
        else if (r < -(ANG_W+1)'(16384))
        begin
            r = -(ANG_W+1)'(16384);
        end
        return r[Q14_W-1:0];
    endfunction

    logic                     pv_reg;
    logic signed [IN_W-1:0]   u1_reg, v1_reg;
    logic signed [SQ1_W-1:0]  uu1_reg, uv1_reg, vv1_reg;

    logic [CNT_W-1:0]         count_reg;
    logic signed [SUM_W-1:0]  sum_u_reg, sum_v_reg;
    logic signed [SQ_W-1:0]   sum_uv_reg, sum_uu_reg, sum_vv_reg;
    logic                     ovf_reg;

    logic signed [OPND_W-1:0] op_a, op_b;
    dst_t                     dst;
    logic                     hi, sub, first;
    logic signed [PROD_W-1:0] p_reg;
    logic signed [ACC_W-1:0]  a_reg, b_reg, n_reg;
    logic signed [ACC_W-1:0]  term, base, res;

    fit_status_t              status_reg;
    logic                     b_neg_reg, y_neg_reg;
    logic [ACC_W-1:0]         xm_reg, ym_reg, mx;
    logic signed [ANG_W-1:0]  x_reg, y_reg, z_reg;
    logic signed [ANG_W-1:0]  xs, ys, at, phi;
    logic signed [Q14_W-1:0]  la_reg, lb_reg;
    logic signed [ANG_W-1:0]  cc, ss;

    logic [ACC_W-1:0]         nmag, nsum;
    logic                     n_neg_reg;
    logic [DIV_W-1:0]         q_reg;
    logic [CNT_W-1:0]         rem_reg;
    logic [CNT_W:0]           trial;
    logic signed [LC_W-1:0]   lc;

    logic                     out_valid_reg;
    logic signed [Q14_W-1:0]  out_a_reg, out_b_reg;
    logic signed [LC_W-1:0]   out_c_reg;
    fit_status_t              out_status_reg;
    logic                     do_load;

    assign stat.out_free   = !out_valid_reg || out_ready;
    assign stat.overflowed = ovf_reg;
    assign stat.ab_zero    = (a_reg == '0) && (b_reg == '0);
    assign mx              = (xm_reg > ym_reg) ? xm_reg : ym_reg;
    assign stat.norm_ok    = (mx[ACC_W-1:FRAC_BITS] == '0) && mx[FRAC_BITS-1];
    assign do_load         = cmd.load && stat.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            u1_reg  <= in_u;
            v1_reg  <= in_v;
            uu1_reg <= in_u * in_u;
            uv1_reg <= in_u * in_v;
            vv1_reg <= in_v * in_v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_u_reg  <= '0;
            sum_v_reg  <= '0;
            sum_uv_reg <= '0;
            sum_uu_reg <= '0;
            sum_vv_reg <= '0;
            ovf_reg    <= 1'b0;
        end
        else if (do_load)
        begin
            count_reg  <= '0;
            sum_u_reg  <= '0;
            sum_v_reg  <= '0;
            sum_uv_reg <= '0;
            sum_uu_reg <= '0;
            sum_vv_reg <= '0;
            ovf_reg    <= 1'b0;
        end
        else if (pv_reg && !ovf_reg)
        begin
            if (count_reg == CNT_W'(MAX_POINTS))
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                count_reg  <= count_reg + CNT_W'(1);
                sum_u_reg  <= sum_u_reg + SUM_W'(u1_reg);
                sum_v_reg  <= sum_v_reg + SUM_W'(v1_reg);
                sum_uv_reg <= sum_uv_reg + SQ_W'(uv1_reg);
                sum_uu_reg <= sum_uu_reg + SQ_W'(uu1_reg);
                sum_vv_reg <= sum_vv_reg + SQ_W'(vv1_reg);
            end
        end
    end

    always_comb
    begin
        op_a  = OPND_W'(count_reg);
        op_b  = '0;
        dst   = DST_A;
        hi    = 1'b0;
        sub   = 1'b0;
        first = 1'b0;
        unique case (cmd.op)
            OP_N_UV_LO:
            begin
                op_b  = OPND_W'(sum_uv_reg[HALF_W-1:0]);
                first = 1'b1;
            end
            OP_N_UV_HI:
            begin
                op_b = OPND_W'(signed'(sum_uv_reg[SQ_W-1:HALF_W]));
                hi   = 1'b1;
            end
            OP_SU_SV:
            begin
                op_a = OPND_W'(sum_u_reg);
                op_b = OPND_W'(sum_v_reg);
                sub  = 1'b1;
            end
            OP_N_UU_LO:
            begin
                op_b  = OPND_W'(sum_uu_reg[HALF_W-1:0]);
                dst   = DST_B;
                first = 1'b1;
            end
            OP_N_UU_HI:
            begin
                op_b = OPND_W'(signed'(sum_uu_reg[SQ_W-1:HALF_W]));
                dst  = DST_B;
                hi   = 1'b1;
            end
            OP_N_VV_LO:
            begin
                op_b = OPND_W'(sum_vv_reg[HALF_W-1:0]);
                dst  = DST_B;
                sub  = 1'b1;
            end
            OP_N_VV_HI:
            begin
                op_b = OPND_W'(signed'(sum_vv_reg[SQ_W-1:HALF_W]));
                dst  = DST_B;
                hi   = 1'b1;
                sub  = 1'b1;
            end
            OP_SU_SU:
            begin
                op_a = OPND_W'(sum_u_reg);
                op_b = OPND_W'(sum_u_reg);
                dst  = DST_B;
                sub  = 1'b1;
            end
            OP_SV_SV:
            begin
                op_a = OPND_W'(sum_v_reg);
                op_b = OPND_W'(sum_v_reg);
                dst  = DST_B;
            end
            OP_SU_LA:
            begin
                op_a  = OPND_W'(sum_u_reg);
                op_b  = OPND_W'(la_reg);
                dst   = DST_N;
                first = 1'b1;
            end
            OP_SV_LB:
            begin
                op_a = OPND_W'(sum_v_reg);
                op_b = OPND_W'(lb_reg);
                dst  = DST_N;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        term = ACC_W'(p_reg);
        if (hi)
        begin
            term = term <<< HALF_W;
        end
        unique case (dst)
            DST_A:   base = a_reg;
            DST_B:   base = b_reg;
            default: base = n_reg;
        endcase
        if (first)
        begin
            base = '0;
        end
        res = sub ? (base - term) : (base + term);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            p_reg <= op_a * op_b;
        end
        if (cmd.acc)
        begin
            unique case (dst)
                DST_A:   a_reg <= res;
                DST_B:   b_reg <= res;
                default: n_reg <= res;
            endcase
        end
    end

    assign xs  = x_reg >>> cmd.step;
    assign ys  = y_reg >>> cmd.step;
    assign at  = signed'(atan_step(cmd.step));
    assign phi = y_neg_reg ? -z_reg : z_reg;

    always_comb
    begin
        if (b_neg_reg)
        begin
            cc = x_reg;
            ss = y_reg;
        end
        else
        begin
            cc = y_reg;
            ss = -x_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            b_neg_reg <= b_reg[ACC_W-1];
            y_neg_reg <= a_reg[ACC_W-1] ^ b_reg[ACC_W-1];
            xm_reg    <= b_reg[ACC_W-1] ? ACC_W'(-b_reg) : ACC_W'(b_reg);
            ym_reg    <= (a_reg[ACC_W-1] ? ACC_W'(-a_reg) : ACC_W'(a_reg)) << 1;
        end
        else if (cmd.norm)
        begin
            if (stat.norm_ok)
            begin
                x_reg <= ANG_W'(xm_reg[FRAC_BITS-1:0]);
                y_reg <= ANG_W'(ym_reg[FRAC_BITS-1:0]);
                z_reg <= '0;
            end
            else if (mx[ACC_W-1:FRAC_BITS] != '0)
            begin
                xm_reg <= xm_reg >> 1;
                ym_reg <= ym_reg >> 1;
            end
            else
            begin
                xm_reg <= xm_reg << 1;
                ym_reg <= ym_reg << 1;
            end
        end
        if (cmd.vec)
        begin
            if (y_reg > 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
        end
        if (cmd.rot_init)
        begin
            x_reg <= ROT_START;
            y_reg <= '0;
            z_reg <= phi >>> 1;
        end
        if (cmd.rot)
        begin
            if (!z_reg[ANG_W-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
        if (cmd.fin)
        begin
            la_reg <= to_q14(cc);
            lb_reg <= to_q14(ss);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= FS_OK;
        end
        else if (cmd.check)
        begin
            if (ovf_reg)
            begin
                status_reg <= FS_OVERFLOW;
            end
            else if (stat.ab_zero)
            begin
                status_reg <= FS_UNDEF;
            end
            else
            begin
                status_reg <= FS_OK;
            end
        end
    end

    assign nmag  = n_reg[ACC_W-1] ? ACC_W'(-n_reg) : ACC_W'(n_reg);
    assign nsum  = nmag + (ACC_W'(count_reg) << 13);
    assign trial = {rem_reg, q_reg[DIV_W-1]};

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            n_neg_reg <= n_reg[ACC_W-1];
            q_reg     <= nsum[DIV_W+13:14];
            rem_reg   <= '0;
        end
        else if (cmd.div)
        begin
            if (trial >= {1'b0, count_reg})
            begin
                rem_reg <= CNT_W'(trial - {1'b0, count_reg});
                q_reg   <= {q_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[CNT_W-1:0];
                q_reg   <= {q_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        if (n_neg_reg)
        begin
            lc = (q_reg > DIV_W'(65535)) ? LC_W'(65535) : LC_W'(q_reg);
        end
        else
        begin
            lc = (q_reg > DIV_W'(65536)) ? -LC_W'(65536) : -LC_W'(q_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (do_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            out_status_reg <= status_reg;
            if (status_reg == FS_OK)
            begin
                out_a_reg <= la_reg;
                out_b_reg <= lb_reg;
                out_c_reg <= lc;
            end
            else
            begin
                out_a_reg <= '0;
                out_b_reg <= '0;
                out_c_reg <= '0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_a      = out_a_reg;
    assign out_b      = out_b_reg;
    assign out_c      = out_c_reg;
    assign out_status = out_status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond limit");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> count_reg == CNT_W'(MAX_POINTS))
        else $error("overflow flagged below limit");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != FS_OK) |->
            (out_a_reg == '0 && out_b_reg == '0 && out_c_reg == '0))
        else $error("error result carries a line");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        do_load |=> (count_reg == '0 && !ovf_reg))
        else $error("sums not cleared after fit");

endmodule

FILE: hw/rtl/least_squares_line_fit.sv
// Channel  Dir  Word fields
// points   in   point_u, point_v (Q11.4), is_last
// fit      out  line_a, line_b (Q1.14), line_c (Q12.4), fit_status
//
// Points are taken one per cycle into running sums.
// A word with is_last holds off points while the fit runs: eleven passes of one shared 29x29
// multiplier, up to 29 normalize shifts, two 16-step CORDIC runs and a 30-step divider, plus
// any wait for the sink. An error status skips the normalize, CORDIC, divider and line_c passes.
// Reset and each load clear the sums; new points come in while a result waits for the sink.
module least_squares_line_fit
    import lslf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lslf_pt_if.sink     points,
    lslf_line_if.source fit
);

    lslf_cmd_t  cmd;
    lslf_stat_t stat;
    logic       in_fire;

    assign points.ready = cmd.in_ready;
    assign in_fire      = points.valid && cmd.in_ready;

    lslf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (points.valid),
        .in_last  (points.is_last),
        .stat     (stat),
        .cmd      (cmd)
    );

    lslf_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_fire    (in_fire),
        .in_u       (points.point_u),
        .in_v       (points.point_v),
        .out_ready  (fit.ready),
        .out_valid  (fit.valid),
        .out_a      (fit.line_a),
        .out_b      (fit.line_b),
        .out_c      (fit.line_c),
        .out_status (fit.fit_status)
    );

endmodule
